>>> design/uvsg_pkg.sv
package uvsg_pkg;

   localparam int CNT_W       = 9;
   localparam int IDX_W       = 17;
   localparam int TEX_W       = 17;
   localparam int POS_W       = 16;
   localparam int ANG_W       = 32;
   localparam int TEX_FRAC    = 16;

   localparam int DIV_STAGES  = 8;
   localparam int DIV_STEP    = 4;
   localparam int DIV_LAT     = DIV_STAGES + 1;

   localparam int CORDIC_ITERS  = 30;
   localparam int CORDIC_STEP   = 2;
   localparam int CORDIC_STAGES = CORDIC_ITERS / CORDIC_STEP;
   localparam int CORDIC_LAT    = CORDIC_STAGES + 1;
   localparam int CORDIC_W      = 33;
   localparam int SC_W          = 32;

   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1
   };

   localparam logic CSR_SLICES = 1'b0;
   localparam logic CSR_STACKS = 1'b1;

   typedef struct packed {
      logic             vertex_valid;
      logic             quad_valid;
      logic [IDX_W-1:0] idx_top_left;
      logic [IDX_W-1:0] idx_bottom_left;
      logic [IDX_W-1:0] idx_top_right;
      logic [IDX_W-1:0] idx_bottom_right;
   } uvsg_meta_type;

   typedef struct packed {
      uvsg_meta_type    meta;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } uvsg_side_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic                    vertex_valid;
      logic                    quad_valid;
      logic [IDX_W-1:0]        idx_top_left;
      logic [IDX_W-1:0]        idx_bottom_left;
      logic [IDX_W-1:0]        idx_top_right;
      logic [IDX_W-1:0]        idx_bottom_right;
   } uvsg_result_type;

endpackage

>>> design/uvsg_chan_if.sv
interface uvsg_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] stack_index;
   logic [8:0] slice_index;
   modport source (output valid, stack_index, slice_index, input ready);
   modport sink   (input valid, stack_index, slice_index, output ready);
endinterface

interface uvsg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic [16:0]        tex_u;
   logic [16:0]        tex_v;
   logic               vertex_valid;
   logic               quad_valid;
   logic [16:0]        idx_top_left;
   logic [16:0]        idx_bottom_left;
   logic [16:0]        idx_top_right;
   logic [16:0]        idx_bottom_right;
   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_valid,
                   quad_valid, idx_top_left, idx_bottom_left, idx_top_right,
                   idx_bottom_right, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_valid,
                   quad_valid, idx_top_left, idx_bottom_left, idx_top_right,
                   idx_bottom_right, output ready);
endinterface

>>> design/uvsg_div.sv
// radix-2 restoring division of numer/denom into FRAC fraction bits, rounded
module uvsg_div #(
   parameter int FRAC = 32
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [uvsg_pkg::CNT_W-1:0]    numer,
   input  logic [uvsg_pkg::CNT_W-1:0]    denom,
   output logic [uvsg_pkg::ANG_W-1:0]    ang_out,
   output logic [uvsg_pkg::TEX_W-1:0]    tex_out
);

   localparam int NS = uvsg_pkg::DIV_STAGES;
   localparam int RW = uvsg_pkg::CNT_W + 1;
   localparam int LS = NS - 1;

   logic [RW-1:0]              r_ff    [NS];
   logic [RW-1:0]              r_in    [NS];
   logic [FRAC-1:0]            q_ff    [NS];
   logic [FRAC-1:0]            q_in    [NS];
   logic                       int_ff  [NS];
   logic                       int_in  [NS];
   logic [uvsg_pkg::CNT_W-1:0] d_ff    [NS];
   logic [uvsg_pkg::CNT_W-1:0] d_in    [NS];
   logic [RW-1:0]              rmid_ff [NS];
   logic [RW-1:0]              rmid_in [NS];

   logic [uvsg_pkg::ANG_W-1:0] ang_ff, ang_in;
   logic [uvsg_pkg::TEX_W-1:0] tex_ff, tex_in;

   always_comb begin
      logic [RW-1:0]              rc;
      logic [FRAC-1:0]            qc;
      logic                       ic;
      logic [uvsg_pkg::CNT_W-1:0] dc;
      logic [RW-1:0]              mc;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            dc = denom;
            ic = (numer >= denom);
            rc = ic ? {1'b0, numer - denom} : {1'b0, numer};
            qc = '0;
            mc = '0;
         end else begin
            dc = d_ff[s-1];
            ic = int_ff[s-1];
            rc = r_ff[s-1];
            qc = q_ff[s-1];
            mc = rmid_ff[s-1];
         end
         for (int j = 0; j < uvsg_pkg::DIV_STEP; j++) begin
            if (s * uvsg_pkg::DIV_STEP + j < FRAC) begin
               rc = {rc[RW-2:0], 1'b0};
               if (rc >= {1'b0, dc}) begin
                  rc = rc - {1'b0, dc};
                  qc = {qc[FRAC-2:0], 1'b1};
               end else begin
                  qc = {qc[FRAC-2:0], 1'b0};
               end
            end
         end
         if ((s + 1) * uvsg_pkg::DIV_STEP == uvsg_pkg::TEX_FRAC) begin
            mc = rc;
         end
         r_in[s]    = rc;
         q_in[s]    = qc;
         int_in[s]  = ic;
         d_in[s]    = dc;
         rmid_in[s] = mc;
      end
   end

   always_comb begin
      logic [RW-1:0] half;
      logic          c_end;
      logic          c_mid;
      logic [FRAC:0] sum;
      half   = {2'b00, d_ff[LS][uvsg_pkg::CNT_W-1:1]};
      c_end  = (r_ff[LS] + half) >= {1'b0, d_ff[LS]};
      c_mid  = (rmid_ff[LS] + half) >= {1'b0, d_ff[LS]};
      sum    = {int_ff[LS], q_ff[LS]} + (FRAC+1)'(c_end);
      ang_in = sum[uvsg_pkg::ANG_W-1:0];
      tex_in = {int_ff[LS], q_ff[LS][FRAC-1 -: uvsg_pkg::TEX_FRAC]}
               + uvsg_pkg::TEX_W'(c_mid);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            r_ff[s]    <= r_in[s];
            q_ff[s]    <= q_in[s];
            int_ff[s]  <= int_in[s];
            d_ff[s]    <= d_in[s];
            rmid_ff[s] <= rmid_in[s];
         end
         ang_ff <= ang_in;
         tex_ff <= tex_in;
      end
   end

   assign ang_out = ang_ff;
   assign tex_out = tex_ff;

endmodule

>>> design/uvsg_cordic.sv
// rotation-mode CORDIC, two iterations per stage, quadrant restored at the end
module uvsg_cordic (
   input  logic                              clock,
   input  logic                              en,
   input  logic [uvsg_pkg::ANG_W-1:0]        ang,
   output logic signed [uvsg_pkg::SC_W-1:0]  cos_out,
   output logic signed [uvsg_pkg::SC_W-1:0]  sin_out
);

   localparam int NS = uvsg_pkg::CORDIC_STAGES;
   localparam int CW = uvsg_pkg::CORDIC_W;

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   logic signed [CW-1:0] x_ff [NS];
   logic signed [CW-1:0] x_in [NS];
   logic signed [CW-1:0] y_ff [NS];
   logic signed [CW-1:0] y_in [NS];
   logic signed [31:0]   z_ff [NS];
   logic signed [31:0]   z_in [NS];
   quad_type             q_ff [NS];
   quad_type             q_in [NS];

   logic signed [uvsg_pkg::SC_W-1:0] cos_ff, cos_in, sin_ff, sin_in;

   always_comb begin
      logic signed [CW-1:0] xc, yc, dx, dy;
      logic signed [31:0]   zc;
      quad_type             qc;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            xc = uvsg_pkg::CORDIC_START;
            yc = '0;
            zc = {2'b00, ang[29:0]};
            qc = quad_type'(ang[31:30]);
         end else begin
            xc = x_ff[s-1];
            yc = y_ff[s-1];
            zc = z_ff[s-1];
            qc = q_ff[s-1];
         end
         for (int j = 0; j < uvsg_pkg::CORDIC_STEP; j++) begin
            dx = yc >>> (s * uvsg_pkg::CORDIC_STEP + j);
            dy = xc >>> (s * uvsg_pkg::CORDIC_STEP + j);
            if (!zc[31]) begin
               xc = xc - dx;
               yc = yc + dy;
               zc = zc - $signed(uvsg_pkg::ATAN_TURNS[s * uvsg_pkg::CORDIC_STEP + j]);
            end else begin
               xc = xc + dx;
               yc = yc - dy;
               zc = zc + $signed(uvsg_pkg::ATAN_TURNS[s * uvsg_pkg::CORDIC_STEP + j]);
            end
         end
         x_in[s] = xc;
         y_in[s] = yc;
         z_in[s] = zc;
         q_in[s] = qc;
      end
   end

   always_comb begin
      logic signed [CW-1:0] xl, yl, nx, ny;
      xl = x_ff[NS-1];
      yl = y_ff[NS-1];
      nx = -xl;
      ny = -yl;
      case (q_ff[NS-1])
         QUAD_I: begin
            cos_in = xl[uvsg_pkg::SC_W-1:0];
            sin_in = yl[uvsg_pkg::SC_W-1:0];
         end
         QUAD_II: begin
            cos_in = ny[uvsg_pkg::SC_W-1:0];
            sin_in = xl[uvsg_pkg::SC_W-1:0];
         end
         QUAD_III: begin
            cos_in = nx[uvsg_pkg::SC_W-1:0];
            sin_in = ny[uvsg_pkg::SC_W-1:0];
         end
         default: begin
            cos_in = yl[uvsg_pkg::SC_W-1:0];
            sin_in = nx[uvsg_pkg::SC_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            x_ff[s] <= x_in[s];
            y_ff[s] <= y_in[s];
            z_ff[s] <= z_in[s];
            q_ff[s] <= q_in[s];
         end
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

>>> design/uvsg_post.sv
// products, rounding to coordinate format, result register
module uvsg_post #(
   parameter int COORD_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [uvsg_pkg::SC_W-1:0]  cos_theta,
   input  logic signed [uvsg_pkg::SC_W-1:0]  sin_theta,
   input  logic signed [uvsg_pkg::SC_W-1:0]  cos_phi,
   input  logic signed [uvsg_pkg::SC_W-1:0]  sin_phi,
   input  uvsg_pkg::uvsg_side_type           side,
   output logic                              out_valid,
   output uvsg_pkg::uvsg_result_type         result
);

   localparam int XY_SH = 60 - COORD_FRAC_BITS;
   localparam int Z_SH  = 30 - COORD_FRAC_BITS;
   localparam logic signed [63:0] XY_HALF = 64'sd1 <<< (XY_SH - 1);
   localparam logic signed [63:0] Z_HALF  =
      (Z_SH > 0) ? (64'sd1 <<< ((Z_SH > 0) ? (Z_SH - 1) : 0)) : 64'sd0;
   localparam logic signed [63:0] LIM     = 64'sd1 <<< COORD_FRAC_BITS;

   function automatic logic [uvsg_pkg::POS_W-1:0] to_coord(
      input logic signed [63:0] v,
      input logic signed [63:0] half,
      input int                 sh
   );
      logic signed [63:0] r;
      r = (v + half) >>> sh;
      if (r > LIM) begin
         r = LIM;
      end
      if (r < -LIM) begin
         r = -LIM;
      end
      return r[uvsg_pkg::POS_W-1:0];
   endfunction

   logic                    vld_m_ff;
   logic signed [63:0]      px_ff, py_ff, pz_ff;
   uvsg_pkg::uvsg_side_type side_m_ff;

   logic                      vld_f_ff;
   uvsg_pkg::uvsg_result_type res_ff, res_in;

   always_comb begin
      res_in = '0;
      if (side_m_ff.meta.vertex_valid) begin
         res_in.pos_x            = to_coord(px_ff, XY_HALF, XY_SH);
         res_in.pos_y            = to_coord(py_ff, XY_HALF, XY_SH);
         res_in.pos_z            = to_coord(pz_ff, Z_HALF, Z_SH);
         res_in.tex_u            = side_m_ff.tex_u;
         res_in.tex_v            = side_m_ff.tex_v;
         res_in.vertex_valid     = 1'b1;
         res_in.quad_valid       = side_m_ff.meta.quad_valid;
         res_in.idx_top_left     = side_m_ff.meta.idx_top_left;
         res_in.idx_bottom_left  = side_m_ff.meta.idx_bottom_left;
         res_in.idx_top_right    = side_m_ff.meta.idx_top_right;
         res_in.idx_bottom_right = side_m_ff.meta.idx_bottom_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_m_ff <= 1'b0;
         vld_f_ff <= 1'b0;
      end else if (en) begin
         vld_m_ff <= in_valid;
         vld_f_ff <= vld_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff     <= 64'(sin_phi) * 64'(cos_theta);
         py_ff     <= 64'(sin_phi) * 64'(sin_theta);
         pz_ff     <= 64'(cos_phi);
         side_m_ff <= side;
         res_ff    <= res_in;
      end
   end

   assign out_valid = vld_f_ff;
   assign result    = res_ff;

endmodule

>>> design/uv_sphere_vertex_generator_top.sv
// channel   dir  handshake      payload
// req_chan  in   valid/ready    stack_index, slice_index
// rsp_chan  out  valid/ready    pos_x/y/z, tex_u/v, vertex/quad valid, 4 indices
// csr_*     in   csr_we         csr_index, csr_wdata
//
// One transaction per cycle in and out; from acceptance to rsp_chan.valid the
// path is 9 divider stages, 16 CORDIC stages, multiply and round.
// The whole pipeline advances as one; it holds when rsp_chan.valid is high
// and rsp_chan.ready is low, and req_chan.ready is low only then.
// Synchronous reset clears the stage valid bits and loads the counts 32 and 16.
module uv_sphere_vertex_generator_top #(
   parameter int MAX_SLICES      = 256,
   parameter int MAX_STACKS      = 256,
   parameter int COORD_FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   uvsg_req_if.sink                   req_chan,
   uvsg_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [uvsg_pkg::CNT_W-1:0] csr_wdata
);

   localparam int L1 = uvsg_pkg::DIV_LAT;
   localparam int L2 = uvsg_pkg::CORDIC_LAT;

   logic [uvsg_pkg::CNT_W-1:0] slices_ff, stacks_ff;
   logic [uvsg_pkg::CNT_W-1:0] slices_eff, stacks_eff;
   logic                       en;
   logic                       out_valid;
   uvsg_pkg::uvsg_result_type  result;
   uvsg_pkg::uvsg_meta_type    meta_in;

   logic                    vld1_ff  [L1];
   uvsg_pkg::uvsg_meta_type meta_ff  [L1];
   logic                    vld2_ff  [L2];
   uvsg_pkg::uvsg_side_type side_ff  [L2];
   uvsg_pkg::uvsg_side_type side_in;

   logic [uvsg_pkg::ANG_W-1:0] theta, phi;
   logic [uvsg_pkg::TEX_W-1:0] tex_u, tex_v;
   logic signed [uvsg_pkg::SC_W-1:0] cos_theta, sin_theta, cos_phi, sin_phi;

   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= 9'd32;
         stacks_ff <= 9'd16;
      end else if (csr_we) begin
         case (csr_index)
            uvsg_pkg::CSR_SLICES: slices_ff <= csr_wdata;
            uvsg_pkg::CSR_STACKS: stacks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (slices_ff == '0) begin
         slices_eff = 9'd1;
      end else if ({23'd0, slices_ff} > 32'(MAX_SLICES)) begin
         slices_eff = uvsg_pkg::CNT_W'(MAX_SLICES);
      end else begin
         slices_eff = slices_ff;
      end
      if (stacks_ff == '0) begin
         stacks_eff = 9'd1;
      end else if ({23'd0, stacks_ff} > 32'(MAX_STACKS)) begin
         stacks_eff = uvsg_pkg::CNT_W'(MAX_STACKS);
      end else begin
         stacks_eff = stacks_ff;
      end
   end

   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      logic [9:0]  stride;
      logic [19:0] tl, bl;
      stride  = {1'b0, slices_eff} + 10'd1;
      tl      = 20'(req_chan.stack_index) * 20'(stride) + 20'(req_chan.slice_index);
      bl      = tl + 20'(stride);
      meta_in = '0;
      meta_in.vertex_valid = (req_chan.stack_index <= stacks_eff)
                          && (req_chan.slice_index <= slices_eff);
      if ((req_chan.stack_index < stacks_eff) && (req_chan.slice_index < slices_eff)) begin
         meta_in.quad_valid       = 1'b1;
         meta_in.idx_top_left     = tl[uvsg_pkg::IDX_W-1:0];
         meta_in.idx_bottom_left  = bl[uvsg_pkg::IDX_W-1:0];
         meta_in.idx_top_right    = 17'(tl + 20'd1);
         meta_in.idx_bottom_right = 17'(bl + 20'd1);
      end
   end

   assign side_in = '{meta: meta_ff[L1-1], tex_u: tex_u, tex_v: tex_v};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L1; i++) begin
            vld1_ff[i] <= 1'b0;
         end
         for (int i = 0; i < L2; i++) begin
            vld2_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld1_ff[0] <= req_chan.valid;
         for (int i = 1; i < L1; i++) begin
            vld1_ff[i] <= vld1_ff[i-1];
         end
         vld2_ff[0] <= vld1_ff[L1-1];
         for (int i = 1; i < L2; i++) begin
            vld2_ff[i] <= vld2_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i < L1; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
         side_ff[0] <= side_in;
         for (int i = 1; i < L2; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   uvsg_div #(.FRAC(32)) u_div_slice (
      .clock   (clock),
      .en      (en),
      .numer   (req_chan.slice_index),
      .denom   (slices_eff),
      .ang_out (theta),
      .tex_out (tex_u)
   );

   uvsg_div #(.FRAC(31)) u_div_stack (
      .clock   (clock),
      .en      (en),
      .numer   (req_chan.stack_index),
      .denom   (stacks_eff),
      .ang_out (phi),
      .tex_out (tex_v)
   );

   uvsg_cordic u_cordic_theta (
      .clock   (clock),
      .en      (en),
      .ang     (theta),
      .cos_out (cos_theta),
      .sin_out (sin_theta)
   );

   uvsg_cordic u_cordic_phi (
      .clock   (clock),
      .en      (en),
      .ang     (phi),
      .cos_out (cos_phi),
      .sin_out (sin_phi)
   );

   uvsg_post #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld2_ff[L2-1]),
      .cos_theta (cos_theta),
      .sin_theta (sin_theta),
      .cos_phi   (cos_phi),
      .sin_phi   (sin_phi),
      .side      (side_ff[L2-1]),
      .out_valid (out_valid),
      .result    (result)
   );

   assign rsp_chan.valid            = out_valid;
   assign rsp_chan.pos_x            = result.pos_x;
   assign rsp_chan.pos_y            = result.pos_y;
   assign rsp_chan.pos_z            = result.pos_z;
   assign rsp_chan.tex_u            = result.tex_u;
   assign rsp_chan.tex_v            = result.tex_v;
   assign rsp_chan.vertex_valid     = result.vertex_valid;
   assign rsp_chan.quad_valid       = result.quad_valid;
   assign rsp_chan.idx_top_left     = result.idx_top_left;
   assign rsp_chan.idx_bottom_left  = result.idx_bottom_left;
   assign rsp_chan.idx_top_right    = result.idx_top_right;
   assign rsp_chan.idx_bottom_right = result.idx_bottom_right;

endmodule

>>> sim/tb_uv_sphere_vertex_generator_top.sv
module tb_uv_sphere_vertex_generator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SL = 256;
   localparam int MAX_ST = 256;
   localparam int FRAC   = 14;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [8:0] stack_index;
      logic [8:0] slice_index;
   } grid_point_type;

   // turn-angle sine/cosine in Q2.30, returned in c (cos) and s (sin)
   function automatic void turn_sincos(input logic [31:0] ang,
                                       output longint c, output longint s);
      longint x, y, z, dx, dy;
      logic [1:0] q;
      q = ang[31:30];
      z = longint'(ang[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(uvsg_pkg::ATAN_TURNS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(uvsg_pkg::ATAN_TURNS[i]);
         end
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic logic [15:0] round_coord(input longint v, input int from);
      int sh;
      longint lim;
      sh = from - FRAC;
      lim = longint'(1) << FRAC;
      if (sh > 0) v = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[15:0];
   endfunction

   function automatic uvsg_pkg::uvsg_result_type vertex_of(input grid_point_type p,
                                                           input logic [8:0] sl_reg,
                                                           input logic [8:0] st_reg);
      uvsg_pkg::uvsg_result_type r;
      longint unsigned sl, st, sli, sti, stride, tl, bl;
      longint ct, stn, cp, sp;
      logic [31:0] theta, phi;
      r = '0;
      sl = (sl_reg == 0) ? 1 : (sl_reg > MAX_SL ? MAX_SL : sl_reg);
      st = (st_reg == 0) ? 1 : (st_reg > MAX_ST ? MAX_ST : st_reg);
      sli = p.slice_index;
      sti = p.stack_index;
      if (sti > st || sli > sl) return r;
      theta = 32'(((sli << 32) + (sl >> 1)) / sl);
      phi = 32'(((sti << 31) + (st >> 1)) / st);
      turn_sincos(theta, ct, stn);
      turn_sincos(phi, cp, sp);
      r.pos_x = round_coord(sp * ct, 60);
      r.pos_y = round_coord(sp * stn, 60);
      r.pos_z = round_coord(cp, 30);
      r.tex_u = 17'(((sli << 16) + (sl >> 1)) / sl);
      r.tex_v = 17'(((sti << 16) + (st >> 1)) / st);
      r.vertex_valid = 1'b1;
      if (sti < st && sli < sl) begin
         stride = sl + 1;
         tl = sti * stride + sli;
         bl = tl + stride;
         r.quad_valid = 1'b1;
         r.idx_top_left = 17'(tl);
         r.idx_bottom_left = 17'(bl);
         r.idx_top_right = 17'(tl + 1);
         r.idx_bottom_right = 17'(bl + 1);
      end
      return r;
   endfunction

   class vertex_scoreboard;
      uvsg_pkg::uvsg_result_type pending_vertices[$];
      logic [8:0] slices_reg = 9'd32;
      logic [8:0] stacks_reg = 9'd16;
      int mismatches = 0;

      function void note_point(grid_point_type p);
         pending_vertices = {pending_vertices, vertex_of(p, slices_reg, stacks_reg)};
      endfunction

      function void check_vertex(uvsg_pkg::uvsg_result_type got);
         uvsg_pkg::uvsg_result_type want;
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", got);
            return;
         end
         want = pending_vertices.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = uvsg_pkg::CSR_SLICES;
   logic [uvsg_pkg::CNT_W-1:0] csr_wdata = '0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit stim_done = 1'b0;
   longint cycle_count = 0;

   uvsg_req_if req_chan ();
   uvsg_rsp_if rsp_chan ();

   vertex_scoreboard sb = new();

   uv_sphere_vertex_generator_top DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.stack_index = '0;
      req_chan.slice_index = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      uvsg_pkg::uvsg_result_type got;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_point({req_chan.stack_index, req_chan.slice_index});
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.pos_x = rsp_chan.pos_x;
            got.pos_y = rsp_chan.pos_y;
            got.pos_z = rsp_chan.pos_z;
            got.tex_u = rsp_chan.tex_u;
            got.tex_v = rsp_chan.tex_v;
            got.vertex_valid = rsp_chan.vertex_valid;
            got.quad_valid = rsp_chan.quad_valid;
            got.idx_top_left = rsp_chan.idx_top_left;
            got.idx_bottom_left = rsp_chan.idx_bottom_left;
            got.idx_top_right = rsp_chan.idx_top_right;
            got.idx_bottom_right = rsp_chan.idx_bottom_right;
            sb.check_vertex(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_uv_sphere_vertex_generator_top failed");
         $finish;
      end
   end

   task automatic send_point(input logic [8:0] stk, input logic [8:0] slc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.stack_index <= stk;
      req_chan.slice_index <= slc;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_counts(input logic [8:0] slices, input logic [8:0] stacks);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_vertices.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= uvsg_pkg::CSR_SLICES;
      csr_wdata <= slices;
      @(posedge clock);
      csr_index <= uvsg_pkg::CSR_STACKS;
      csr_wdata <= stacks;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.slices_reg = slices;
      sb.stacks_reg = stacks;
   endtask

   task automatic random_phase(input int n, input int idle, input int stall);
      int sl, st;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      sl = (sb.slices_reg == 0) ? 1 : (sb.slices_reg > 256 ? 256 : sb.slices_reg);
      st = (sb.stacks_reg == 0) ? 1 : (sb.stacks_reg > 256 ? 256 : sb.stacks_reg);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 8)
            send_point(9'($urandom_range(st)), 9'($urandom_range(sl)));
         else
            send_point(9'($urandom_range(511)), 9'($urandom_range(511)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: poles, seams, off-grid at default counts
      send_point(9'd0, 9'd0);
      send_point(9'd16, 9'd0);
      send_point(9'd8, 9'd8);
      send_point(9'd15, 9'd31);
      send_point(9'd16, 9'd32);
      send_point(9'd17, 9'd0);
      send_point(9'd0, 9'd33);
      send_point(9'h1FF, 9'h1FF);
      send_point(9'd4, 9'd16);
      send_point(9'd12, 9'd24);
      write_counts(9'd0, 9'd0);
      send_point(9'd0, 9'd0);
      send_point(9'd1, 9'd1);
      send_point(9'd0, 9'd1);
      send_point(9'd2, 9'd2);
      write_counts(9'd256, 9'd256);
      send_point(9'd256, 9'd256);
      send_point(9'd255, 9'd255);
      send_point(9'd128, 9'd64);
      send_point(9'd257, 9'd3);
      write_counts(9'h1FF, 9'h1FF);
      send_point(9'd256, 9'd256);
      send_point(9'd100, 9'd200);
      send_point(9'd257, 9'd257);
      write_counts(9'd3, 9'd2);
      random_phase(120, 0, 0);
      write_counts(9'd256, 9'd256);
      random_phase(150, 47, 0);
      write_counts(9'd1, 9'd1);
      random_phase(60, 0, 47);
      write_counts(9'd32, 9'd16);
      random_phase(150, 26, 26);
      write_counts(9'($urandom_range(511)), 9'($urandom_range(511)));
      random_phase(150, 0, 0);
      write_counts(9'($urandom_range(1, 300)), 9'($urandom_range(1, 300)));
      random_phase(100, 26, 26);
      req_chan.valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (sb.pending_vertices.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_vertices.size() == 0)
         $display("tb_uv_sphere_vertex_generator_top passed");
      else
         $display("tb_uv_sphere_vertex_generator_top failed");
      $finish;
   end
endmodule
